// ----- rtl/mvn_pkg.sv -----
// Shared types and constants for the RGB mean/variance normalizer.
package mvn_pkg;

    localparam int CNT_W     = 21;             // pixel count width
    localparam int SUM_W     = 37;             // signed per-channel sum width
    localparam int SQ_W      = 52;             // per-channel square sum width
    localparam int SMP_W     = 16;             // signed Q8.8 sample width
    localparam int WIDE_W    = 81;             // width of den, num and k*den
    localparam int MAG_W     = 38;             // |n*x - S| and n*98304 width
    localparam int MUL_STEPS = 37;             // shift-add steps per serial product
    localparam int STEP_W    = 6;
    localparam int NUM_SPLIT = 19;             // low half of |d| for the num product
    localparam int NCH       = 3;

    localparam logic [CNT_W-1:0] MAX_PIXELS = CNT_W'(1048576);

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_ACCUM = 2'd1,
        MODE_NORM  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        L_IDLE,
        L_NQ,
        L_SS,
        L_DEN,
        L_D,
        L_NUM_LO,
        L_NUM_HI,
        L_SEARCH,
        L_DONE
    } t_lane_state;

    typedef struct packed {
        logic start;       // begin one normalize request
        logic ack;         // result taken by the merge stage
        logic invalidate;  // statistics changed, cached denominator stale
    } t_lane_ctrl;

    typedef struct packed {
        logic       done;
        logic [7:0] value;
    } t_lane_stat;

endpackage

// ----- rtl/mvn_lane.sv -----
// One channel lane: cached variance term, serial products and byte search.
module mvn_lane (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mvn_pkg::t_lane_ctrl                  i_ctrl,
    input  logic        [mvn_pkg::CNT_W-1:0]     i_count,
    input  logic signed [mvn_pkg::SUM_W-1:0]     i_sum,
    input  logic        [mvn_pkg::SQ_W-1:0]      i_sqsum,
    input  logic signed [mvn_pkg::SMP_W-1:0]     i_sample,
    output mvn_pkg::t_lane_stat                  o_stat
);
    import mvn_pkg::*;

    t_lane_state r_state, n_state;

    logic [WIDE_W-1:0] r_acc, r_mcand, r_nq, r_den, r_num;
    logic [SUM_W-1:0]  r_mplier;
    logic [STEP_W-1:0] r_step;
    logic              r_den_ok, r_zv, r_neg;
    logic [MAG_W-1:0]  r_dmag;
    logic [7:0]        r_y;
    logic [2:0]        r_bit;

    logic [WIDE_W-1:0]    w_acc_next;
    logic                 w_last_step;
    logic [SUM_W-1:0]     w_sum_mag;
    logic signed [SUM_W:0]   w_nx;
    logic signed [SUM_W+1:0] w_d;
    logic [MAG_W-1:0]     w_scale;
    logic [MAG_W-NUM_SPLIT-1:0] w_part;
    logic [MAG_W+MAG_W-NUM_SPLIT-1:0] w_part_prod;
    logic [7:0]           w_t;
    logic signed [8:0]    w_k;
    logic [7:0]           w_kmag;
    logic [WIDE_W-1:0]    w_kd;
    logic                 w_num_neg, w_fit;

    assign w_acc_next  = r_acc + (r_mplier[0] ? r_mcand : '0);
    assign w_last_step = (r_step == STEP_W'(MUL_STEPS - 1));
    assign w_sum_mag   = i_sum[SUM_W-1] ? SUM_W'(-i_sum) : SUM_W'(i_sum);

    assign w_nx  = $signed({1'b0, i_count}) * i_sample;
    assign w_d   = (SUM_W+2)'(w_nx) - (SUM_W+2)'(i_sum);
    // n * 98304 = (3n) << 15
    assign w_scale = MAG_W'({i_count, 1'b0} + {1'b0, i_count}) << 15;

    always_comb begin
        if (r_state == L_NUM_LO) begin
            w_part = (MAG_W-NUM_SPLIT)'(r_dmag[NUM_SPLIT-1:0]);
        end else begin
            w_part = r_dmag[MAG_W-1:NUM_SPLIT];
        end
    end
    assign w_part_prod = w_scale * w_part;

    // One step of the byte search: does (t - 128) * den <= signed num hold?
    assign w_t       = r_y | (8'd1 << r_bit);
    assign w_k       = $signed({1'b0, w_t}) - 9'sd128;
    assign w_kmag    = w_k[8] ? 8'(-w_k) : w_k[7:0];
    assign w_kd      = r_den * w_kmag;
    assign w_num_neg = r_neg && (r_num != '0);
    always_comb begin
        if (!w_k[8]) begin
            w_fit = !w_num_neg && (w_kd <= r_num);
        end else begin
            w_fit = !w_num_neg || (w_kd >= r_num);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            L_IDLE:   if (i_ctrl.start) n_state = r_den_ok ? L_D : L_NQ;
            L_NQ:     if (w_last_step) n_state = L_SS;
            L_SS:     if (w_last_step) n_state = L_DEN;
            L_DEN:    n_state = L_D;
            L_D:      n_state = L_NUM_LO;
            L_NUM_LO: n_state = r_zv ? L_DONE : L_NUM_HI;
            L_NUM_HI: n_state = L_SEARCH;
            L_SEARCH: if (r_bit == 3'd0) n_state = L_DONE;
            L_DONE:   if (i_ctrl.ack) n_state = L_IDLE;
            default:  n_state = L_IDLE;
        endcase
    end

    always_comb begin
        o_stat.done  = (r_state == L_DONE);
        o_stat.value = r_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= L_IDLE;
            r_den_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_ctrl.invalidate) r_den_ok <= 1'b0;
            else if (r_state == L_DEN) r_den_ok <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            L_IDLE: begin
                r_acc    <= '0;
                r_mcand  <= WIDE_W'(i_sqsum);
                r_mplier <= SUM_W'(i_count);
                r_step   <= '0;
            end
            L_NQ: begin
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
                r_step   <= r_step + 1'b1;
                r_acc    <= w_acc_next;
                if (w_last_step) begin
                    r_nq     <= w_acc_next;
                    r_acc    <= '0;
                    r_mcand  <= WIDE_W'(w_sum_mag);
                    r_mplier <= w_sum_mag;
                    r_step   <= '0;
                end
            end
            L_SS: begin
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
                r_step   <= r_step + 1'b1;
                r_acc    <= w_acc_next;
            end
            L_DEN: begin
                r_zv  <= (r_nq <= r_acc);
                r_den <= r_nq - r_acc;
            end
            L_D: begin
                r_neg  <= w_d[SUM_W+1];
                r_dmag <= w_d[SUM_W+1] ? MAG_W'(-w_d) : MAG_W'(w_d);
            end
            L_NUM_LO: begin
                r_num <= WIDE_W'(w_part_prod);
                r_y   <= 8'hFF;
            end
            L_NUM_HI: begin
                r_num <= r_num + (WIDE_W'(w_part_prod) << NUM_SPLIT);
                r_y   <= 8'd0;
                r_bit <= 3'd7;
            end
            L_SEARCH: begin
                if (w_fit) r_y <= w_t;
                r_bit <= r_bit - 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// ----- rtl/rgb_mean_variance_normalizer.sv -----
// Top level: statistics accumulation, three channel lanes and result merge.
//
// Normalizes each channel of an RGB stream in two passes. A request with
// tuser mode 0 clears the statistics, mode 1 adds the pixel to the count,
// sums and square sums (ignored once the count reaches its limit), mode 2
// returns floor(128 + 128*(x - mean)/(var/3)) per channel clamped to 0..255,
// 255 for a channel of zero variance, and zeros with the no-statistics flag
// when nothing was accumulated. Modes 0, 1 and 3 give no response. A mode-2
// request runs the three lanes side by side: the first one after the
// statistics change also forms n*Q - S*S in each lane by two 37-step
// shift-add products and one subtract; every mode-2 request then runs
// through n*x - S, the split numerator product (low and high half), the
// bitwise byte search from the top bit down, and the hand-over. A finished
// response sits in the output register while the next request is accepted.
module rgb_mean_variance_normalizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // red_in, green_in, blue_in
    input  logic [1:0]  i_s_axis_tuser,   // mode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // red_out, green_out, blue_out
    output logic        o_m_axis_tuser    // no_statistics
);
    import mvn_pkg::*;

    logic [CNT_W-1:0]        r_count;
    logic signed [SUM_W-1:0] r_sum   [NCH];
    logic [SQ_W-1:0]         r_sqsum [NCH];
    logic signed [SMP_W-1:0] r_pix   [NCH];

    logic        r_busy, r_nostat, r_out_valid, r_out_flag;
    logic [23:0] r_out_data;

    logic        w_accept, w_out_free, w_all_done, w_finish;
    t_mode       w_mode;
    t_lane_ctrl  w_ctrl;
    t_lane_stat  w_stat [NCH];
    logic signed [SMP_W-1:0] w_smp [NCH];

    assign o_s_axis_tready = !r_busy;
    assign w_accept        = i_s_axis_tvalid && !r_busy;
    assign w_mode          = t_mode'(i_s_axis_tuser);
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_all_done      = w_stat[0].done && w_stat[1].done && w_stat[2].done;
    // merge: a response is ready when every lane has its byte, or at once
    // for the no-statistics case
    assign w_finish        = r_busy && (r_nostat || w_all_done) && w_out_free;

    always_comb begin
        w_ctrl.start      = w_accept && (w_mode == MODE_NORM) && (r_count != '0);
        w_ctrl.ack        = w_finish && !r_nostat;
        w_ctrl.invalidate = w_accept && ((w_mode == MODE_CLEAR) || (w_mode == MODE_ACCUM));
    end

    for (genvar c = 0; c < NCH; c++) begin : g_lane
        assign w_smp[c] = i_s_axis_tdata[c*SMP_W +: SMP_W];
        mvn_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (w_ctrl),
            .i_count  (r_count),
            .i_sum    (r_sum[c]),
            .i_sqsum  (r_sqsum[c]),
            .i_sample (r_busy ? r_pix[c] : w_smp[c]),
            .o_stat   (w_stat[c])
        );
    end

    // statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int c = 0; c < NCH; c++) begin
                r_sum[c]   <= '0;
                r_sqsum[c] <= '0;
            end
        end else if (w_accept && (w_mode == MODE_CLEAR)) begin
            r_count <= '0;
            for (int c = 0; c < NCH; c++) begin
                r_sum[c]   <= '0;
                r_sqsum[c] <= '0;
            end
        end else if (w_accept && (w_mode == MODE_ACCUM) && (r_count < MAX_PIXELS)) begin
            r_count <= r_count + 1'b1;
            for (int c = 0; c < NCH; c++) begin
                r_sum[c]   <= r_sum[c] + SUM_W'(w_smp[c]);
                r_sqsum[c] <= r_sqsum[c] + SQ_W'(unsigned'(32'(w_smp[c] * w_smp[c])));
            end
        end
    end

    // hold the pixel for the lanes while a request runs
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int c = 0; c < NCH; c++) r_pix[c] <= w_smp[c];
        end
    end

    // request tracking and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_nostat    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept && (w_mode == MODE_NORM)) begin
                r_busy   <= 1'b1;
                r_nostat <= (r_count == '0);
            end else if (w_finish) begin
                r_busy <= 1'b0;
            end
            if (w_finish) r_out_valid <= 1'b1;
            else if (i_m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out_flag <= r_nostat;
            r_out_data <= r_nostat ? 24'd0
                        : {w_stat[2].value, w_stat[1].value, w_stat[0].value};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_flag;

endmodule

// ----- bench/tb_rgb_mean_variance_normalizer.sv -----
// Self-checking bench for the RGB mean/variance normalizer stream block.
module tb_rgb_mean_variance_normalizer;
    timeunit 1ns;
    timeprecision 1ps;
    import mvn_pkg::*;

    typedef struct {
        t_mode             mode;
        logic signed [15:0] red;
        logic signed [15:0] green;
        logic signed [15:0] blue;
    } t_pixel_req;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       no_stats;
    } t_norm_rsp;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 200;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata;   // red_in, green_in, blue_in
    logic [1:0]  i_s_axis_tuser;   // mode
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [23:0] o_m_axis_tdata;   // red_out, green_out, blue_out
    logic        o_m_axis_tuser;   // no_statistics

    rgb_mean_variance_normalizer dut (.*);

    t_pixel_req pending_reqs[$];
    t_norm_rsp  expected_bytes[$];
    t_pixel_req in_flight;
    int         error_count = 0;
    int         cycle_count = 0;
    int         stall_cycles = 0;

    // predictor state
    longint             stat_count;
    logic signed [63:0] stat_sum [3];
    logic signed [63:0] stat_sq  [3];

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // quiet windows: no idling on either side
    function automatic bit idle_now();
        if ((cycle_count % 5000) < 1200) return 1'b0;
        return $urandom_range(99) < 32;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    // largest y in 0..255 with (y-128)*den <= num, exact on wide integers
    function automatic logic [7:0] norm_byte(int ch, logic signed [15:0] x);
        logic signed [127:0] n, s, q, den, num, sq, xs;
        n   = stat_count;
        s   = stat_sum[ch];
        sq  = stat_sq[ch];
        xs  = x;
        den = n * sq - s * s;
        if (den <= 0) return 8'd255;
        num = 128'sd98304 * n * (n * xs - s);
        q   = num / den;
        if ((num % den) != 0 && num < 0) q = q - 1;
        q = q + 128;
        if (q > 255) return 8'd255;
        if (q < 0) return 8'd0;
        return q[7:0];
    endfunction

    task automatic predict_request(t_pixel_req r);
        logic signed [15:0] px [3];
        t_norm_rsp          rsp;
        px[0] = r.red; px[1] = r.green; px[2] = r.blue;
        case (r.mode)
            MODE_CLEAR: begin
                stat_count = 0;
                for (int c = 0; c < 3; c++) begin
                    stat_sum[c] = 0;
                    stat_sq[c]  = 0;
                end
            end
            MODE_ACCUM: begin
                if (stat_count < MAX_PIXELS) begin
                    stat_count++;
                    for (int c = 0; c < 3; c++) begin
                        stat_sum[c] = stat_sum[c] + px[c];
                        stat_sq[c]  = stat_sq[c] + px[c] * px[c];
                    end
                end
            end
            MODE_NORM: begin
                if (stat_count == 0) begin
                    rsp = '{8'd0, 8'd0, 8'd0, 1'b1};
                end else begin
                    rsp.red      = norm_byte(0, px[0]);
                    rsp.green    = norm_byte(1, px[1]);
                    rsp.blue     = norm_byte(2, px[2]);
                    rsp.no_stats = 1'b0;
                end
                expected_bytes = {expected_bytes, rsp};
            end
            default: ;
        endcase
    endtask

    function automatic logic signed [15:0] rand_sample(bit narrow);
        if (narrow) return 16'(int'($urandom_range(0, 2000)) - 1000);
        return 16'($urandom);
    endfunction

    task automatic add_req(t_mode m, logic signed [15:0] r, logic signed [15:0] g,
                           logic signed [15:0] b);
        t_pixel_req q;
        q.mode = m; q.red = r; q.green = g; q.blue = b;
        pending_reqs = {pending_reqs, q};
    endtask

    // Driver: one nonblocking write per signal per edge.
    always @(posedge i_clk) begin
        t_pixel_req nxt;
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
            i_s_axis_tuser  <= MODE_CLEAR;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (i_s_axis_tvalid) predict_request(in_flight);
            if (pending_reqs.size() > 0 && !idle_now()) begin
                nxt = pending_reqs.pop_front();
                in_flight <= nxt;
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= {nxt.blue, nxt.green, nxt.red};
                i_s_axis_tuser  <= nxt.mode;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: random backpressure, in-order compare.
    always @(posedge i_clk) begin
        t_norm_rsp want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= !idle_now();
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch("unexpected response", 1, 0);
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_m_axis_tdata[7:0] !== want.red)
                        report_mismatch("red", o_m_axis_tdata[7:0], want.red);
                    if (o_m_axis_tdata[15:8] !== want.green)
                        report_mismatch("green", o_m_axis_tdata[15:8], want.green);
                    if (o_m_axis_tdata[23:16] !== want.blue)
                        report_mismatch("blue", o_m_axis_tdata[23:16], want.blue);
                    if (o_m_axis_tuser !== want.no_stats)
                        report_mismatch("no_statistics", o_m_axis_tuser, want.no_stats);
                end
            end
        end
    end

    // Watchdog: cycles with no request or response accepted.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_rgb_mean_variance_normalizer: errors");
            $finish;
        end
    end

    initial begin
        int frame_px;
        bit narrow;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = MODE_CLEAR;
        i_m_axis_tready = 1'b0;
        stat_count      = 0;
        for (int c = 0; c < 3; c++) begin
            stat_sum[c] = 0;
            stat_sq[c]  = 0;
        end

        // directed: empty statistics, unused mode, single pixel (zero variance)
        add_req(MODE_NORM, 16'sh7fff, -16'sh8000, 16'sh0000);
        add_req(MODE_NONE, 16'sh1234, 16'sh0001, -16'sh0001);
        add_req(MODE_ACCUM, 16'sh0100, -16'sh0100, 16'sh0000);
        add_req(MODE_NORM, 16'sh0100, 16'sh7fff, -16'sh8000);
        // extremes accumulated, then clamping both ways
        add_req(MODE_ACCUM, 16'sh7fff, -16'sh8000, 16'sh7fff);
        add_req(MODE_ACCUM, -16'sh8000, 16'sh7fff, -16'sh8000);
        add_req(MODE_NORM, 16'sh7fff, -16'sh8000, 16'sh0000);
        add_req(MODE_NORM, -16'sh8000, 16'sh7fff, 16'shffff);
        add_req(MODE_NONE, 16'sh0000, 16'sh0000, 16'sh0000);
        add_req(MODE_NORM, 16'sh0000, 16'sh0001, -16'sh0001);
        add_req(MODE_CLEAR, 16'shffff, 16'shffff, 16'shffff);
        add_req(MODE_NORM, 16'sh0010, 16'sh0020, 16'sh0030);
        add_req(MODE_ACCUM, 16'sh0010, 16'sh0010, 16'sh0020);
        add_req(MODE_ACCUM, 16'sh0030, 16'sh0010, 16'sh0040);
        add_req(MODE_NORM, 16'sh0020, 16'sh0010, 16'sh0030);
        add_req(MODE_NORM, 16'sh0010, 16'sh7000, -16'sh7000);

        // random frames: clear, accumulate, normalize, with some noise
        while (pending_reqs.size() < 700) begin
            narrow   = $urandom_range(1);
            frame_px = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            if ($urandom_range(5) != 0) add_req(MODE_CLEAR, rand_sample(0), rand_sample(0),
                                                rand_sample(0));
            for (int i = 0; i < frame_px; i++) begin
                if ($urandom_range(15) == 0)
                    add_req(MODE_NONE, rand_sample(0), rand_sample(0), rand_sample(0));
                add_req(MODE_ACCUM, rand_sample(narrow), rand_sample(narrow),
                        rand_sample(narrow));
            end
            for (int i = 0; i < $urandom_range(1, 10); i++)
                add_req(MODE_NORM, rand_sample(narrow && $urandom_range(3) != 0),
                        rand_sample(narrow), rand_sample(narrow));
            if ($urandom_range(19) == 0)
                add_req(MODE_CLEAR, rand_sample(0), rand_sample(0), rand_sample(0));
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_reqs.size() == 0);
        @(posedge i_clk);
        while (i_s_axis_tvalid) @(posedge i_clk);
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("tb_rgb_mean_variance_normalizer: clean");
        end else begin
            $display("tb_rgb_mean_variance_normalizer: errors");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/mvn_pkg.sv
rtl/mvn_lane.sv
rtl/rgb_mean_variance_normalizer.sv
bench/tb_rgb_mean_variance_normalizer.sv
